### rtl/strict_priority_landing_queue_unit_defines.svh
// ----------------------------------------------------------------------------
// Strict priority landing queue assertion macros
// Shared property macros for the queue block, with an off switch.
// ----------------------------------------------------------------------------
`ifndef STRICT_PRIORITY_LANDING_QUEUE_UNIT_DEFINES_SVH
`define STRICT_PRIORITY_LANDING_QUEUE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define SPL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define SPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/spl_pkg.sv
// ----------------------------------------------------------------------------
// Strict priority landing queue package
// Sizes, payload structs, sequencer states and address helpers.
// ----------------------------------------------------------------------------
package spl_pkg;

    localparam int NUM_CLASSES = 3;
    localparam int CLASS_DEPTH = 16;
    localparam int PTR_W       = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int FILL_W      = $clog2(CLASS_DEPTH + 1);
    localparam int SLOT_SUM_W  = FILL_W + 1;
    localparam int STAMP_DEPTH = NUM_CLASSES * CLASS_DEPTH;
    localparam int ADDR_W      = $clog2(STAMP_DEPTH);
    localparam int CLS_W       = 2;
    localparam int TICK_W      = 32;
    localparam int PHASE_W     = 16;
    localparam int SUM_W       = 48;

    localparam logic [CLS_W-1:0] CLS_LOW  = 2'd0;
    localparam logic [CLS_W-1:0] CLS_HIGH = 2'd2;

    typedef struct packed {
        logic             arrival_valid;
        logic [CLS_W-1:0] arrival_priority;
    } t_in_item;

    typedef struct packed {
        logic              served;
        logic [CLS_W-1:0]  served_priority;
        logic [TICK_W-1:0] wait_ticks;
        logic              arrival_dropped;
        logic [SUM_W-1:0]  total_wait;
        logic [TICK_W-1:0] served_count;
    } t_out_item;

    // Decision of the queue controller for one tick.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              serve;
        logic [CLS_W-1:0]  serve_cls;
        logic              fresh;
        logic              dropped;
    } t_sched;

    typedef enum logic {
        ST_IDLE,
        ST_FINISH
    } t_state;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [CLS_W-1:0] cls,
                                                    input logic [PTR_W-1:0] ptr);
        slot_addr = ADDR_W'(ADDR_W'(cls) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(ptr));
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        ptr_inc = (ptr == PTR_W'(CLASS_DEPTH - 1)) ? '0 : PTR_W'(ptr + 1'b1);
    endfunction

endpackage

### rtl/spl_stamp_ram.sv
// ----------------------------------------------------------------------------
// Arrival stamp memory
// One write port and one registered read port over all class slots.
// ----------------------------------------------------------------------------
module spl_stamp_ram import spl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [TICK_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [TICK_W-1:0] o_rd_data
);

    logic [TICK_W-1:0] mem [STAMP_DEPTH];
    logic [TICK_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/spl_queue_ctrl.sv
// ----------------------------------------------------------------------------
// Queue pointer controller
// Keeps head and fill per class and decides enqueue, drop and service.
// ----------------------------------------------------------------------------
module spl_queue_ctrl import spl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  logic     i_serve_slot,
    input  t_in_item i_item,
    output t_sched   o_sched
);

    logic [PTR_W-1:0]      r_head [NUM_CLASSES];
    logic [PTR_W-1:0]      n_head [NUM_CLASSES];
    logic [FILL_W-1:0]     r_fill [NUM_CLASSES];
    logic [FILL_W-1:0]     n_fill [NUM_CLASSES];
    logic [FILL_W-1:0]     w_fill_after [NUM_CLASSES];
    logic [CLS_W-1:0]      w_cls;
    logic [PTR_W-1:0]      w_enq_head;
    logic [FILL_W-1:0]     w_enq_fill;
    logic [SLOT_SUM_W-1:0] w_slot_sum;
    logic [PTR_W-1:0]      w_slot;
    logic                  w_enq;
    logic                  w_serve;
    logic [CLS_W-1:0]      w_sc;
    logic [PTR_W-1:0]      w_srv_head;
    logic [FILL_W-1:0]     w_srv_fill;

    // A priority code above the high class saturates to the high class.
    assign w_cls = (i_item.arrival_priority > CLS_HIGH) ? CLS_HIGH : i_item.arrival_priority;

    always_comb begin
        w_enq_head = '0;
        w_enq_fill = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (w_cls == CLS_W'(c)) begin
                w_enq_head = r_head[c];
                w_enq_fill = r_fill[c];
            end
        end
    end

    assign w_enq      = i_item.arrival_valid && (w_enq_fill != FILL_W'(CLASS_DEPTH));
    assign w_slot_sum = SLOT_SUM_W'(w_enq_head) + SLOT_SUM_W'(w_enq_fill);
    assign w_slot     = (w_slot_sum >= SLOT_SUM_W'(CLASS_DEPTH))
                      ? PTR_W'(w_slot_sum - SLOT_SUM_W'(CLASS_DEPTH))
                      : PTR_W'(w_slot_sum);

    // Highest non-empty class after the arrival wins the service slot.
    always_comb begin
        w_serve    = 1'b0;
        w_sc       = CLS_LOW;
        w_srv_head = '0;
        w_srv_fill = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            w_fill_after[c] = r_fill[c] + FILL_W'(w_enq && (w_cls == CLS_W'(c)));
            if (i_serve_slot && (w_fill_after[c] != '0)) begin
                w_serve    = 1'b1;
                w_sc       = CLS_W'(c);
                w_srv_head = r_head[c];
                w_srv_fill = r_fill[c];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (w_serve && (w_sc == CLS_W'(c))) begin
                n_fill[c] = w_fill_after[c] - 1'b1;
                n_head[c] = ptr_inc(r_head[c]);
            end else begin
                n_fill[c] = w_fill_after[c];
                n_head[c] = r_head[c];
            end
        end
    end

    always_comb begin
        o_sched.wr_en     = i_step && w_enq;
        o_sched.wr_addr   = slot_addr(w_cls, w_slot);
        o_sched.rd_en     = i_step && w_serve;
        o_sched.rd_addr   = slot_addr(w_sc, w_srv_head);
        o_sched.serve     = w_serve;
        o_sched.serve_cls = w_sc;
        // The served entry is this tick's own arrival when its class was empty.
        o_sched.fresh     = w_enq && (w_cls == w_sc) && (w_srv_fill == '0);
        o_sched.dropped   = i_item.arrival_valid && !w_enq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c] <= '0;
                r_fill[c] <= '0;
            end
        end else if (i_step) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c] <= n_head[c];
                r_fill[c] <= n_fill[c];
            end
        end
    end

endmodule

### rtl/strict_priority_landing_queue_unit.sv
// ----------------------------------------------------------------------------
// Strict priority landing queue unit
// Three-class strict priority queue of time-stamped requests with service.
// ----------------------------------------------------------------------------
// Each input transaction is one time tick that may carry an arriving request
// with a class from 0 to 2. The request is stamped with the tick count and
// queued in its class; a full class drops it and flags the drop. On every
// service slot (every service_period ticks, starting at tick 0) the oldest
// entry of the highest non-empty class is served and its wait reported.
// Every input transaction produces exactly one output transaction.
// The stamp memory read issued at acceptance returns in the next cycle, and
// the input stays not-ready until the result is in the output register. The
// result is loaded into the output register in the finish step. When the
// receiver stalls, the result waits in the output register and the block
// holds the following tick in its finish step until the register frees up.
// A synchronous reset clears the tick count, service phase, pointers and
// totals and sets the service period to 1; the stamp memory keeps its
// contents and is read at an unfilled slot only for a served same-tick arrival.
// ----------------------------------------------------------------------------
`include "strict_priority_landing_queue_unit_defines.svh"

module strict_priority_landing_queue_unit import spl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               i_cfg_we,
    input  logic [PHASE_W-1:0] i_cfg_wdata
);

    t_state              r_state;
    t_state              n_state;
    logic [PHASE_W-1:0]  r_period;
    logic [PHASE_W-1:0]  r_phase;
    logic [PHASE_W-1:0]  n_phase;
    logic [PHASE_W-1:0]  w_phase_inc;
    logic [TICK_W-1:0]   r_tick;
    logic [SUM_W-1:0]    r_wait_sum;
    logic [SUM_W-1:0]    n_wait_sum;
    logic [TICK_W-1:0]   r_served_total;
    logic [TICK_W-1:0]   n_served_total;
    logic                r_out_valid;
    t_out_item           r_out;
    t_out_item           n_out;

    // Context of the tick in flight between acceptance and finish.
    logic                r_serve;
    logic [CLS_W-1:0]    r_serve_cls;
    logic                r_fresh;
    logic                r_dropped;
    logic [TICK_W-1:0]   r_svc_tick;

    logic                w_step;
    logic                w_load;
    logic                w_out_free;
    logic [TICK_W-1:0]   w_rd_data;
    logic [TICK_W-1:0]   w_wait;
    t_sched              w_sched;

    spl_queue_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_serve_slot (r_phase == '0),
        .i_item       (i_in_data),
        .o_sched      (w_sched)
    );

    // The arrival of a tick is written with the current tick as its stamp.
    spl_stamp_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_sched.wr_en),
        .i_wr_addr (w_sched.wr_addr),
        .i_wr_data (r_tick),
        .i_rd_en   (w_sched.rd_en),
        .i_rd_addr (w_sched.rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_out_free = !r_out_valid || i_out_ready;

    // Next-state logic of the two-step sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output decode of the sequencer.
    always_comb begin
        o_in_ready = 1'b0;
        w_load     = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_in_ready = 1'b1;
            ST_FINISH: w_load     = w_out_free;
            default: begin
                o_in_ready = 1'b0;
                w_load     = 1'b0;
            end
        endcase
    end

    assign w_step = i_in_valid && o_in_ready;

    // The phase wraps to zero once it reaches the period; a period of zero
    // therefore serves on every tick, like a period of one.
    assign w_phase_inc = r_phase + 1'b1;
    assign n_phase     = (w_phase_inc >= r_period) ? '0 : w_phase_inc;

    // A served arrival of the same tick has not been read back and waits zero.
    assign w_wait = (r_serve && !r_fresh) ? (r_svc_tick - w_rd_data) : '0;

    always_comb begin
        n_wait_sum     = r_wait_sum;
        n_served_total = r_served_total;
        if (r_serve) begin
            n_wait_sum     = r_wait_sum + SUM_W'(w_wait);
            n_served_total = r_served_total + 1'b1;
        end
        n_out.served          = r_serve;
        n_out.served_priority = r_serve ? r_serve_cls : CLS_LOW;
        n_out.wait_ticks      = w_wait;
        n_out.arrival_dropped = r_dropped;
        n_out.total_wait      = n_wait_sum;
        n_out.served_count    = n_served_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_period       <= PHASE_W'(1);
            r_phase        <= '0;
            r_tick         <= '0;
            r_wait_sum     <= '0;
            r_served_total <= '0;
            r_out_valid    <= 1'b0;
            r_serve        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            if (w_step) begin
                r_phase <= n_phase;
                r_tick  <= r_tick + 1'b1;
                r_serve <= w_sched.serve;
            end
            if (w_load) begin
                r_wait_sum     <= n_wait_sum;
                r_served_total <= n_served_total;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_serve_cls <= w_sched.serve_cls;
            r_fresh     <= w_sched.fresh;
            r_dropped   <= w_sched.dropped;
            r_svc_tick  <= r_tick;
        end
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // One tick is in flight at a time.
    `SPL_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, w_step, !o_in_ready, "input ready while a tick is in flight")
    // An idle result reports neither a class nor a wait.
    `SPL_ASSERT_IMPL(a_idle_result_clean, i_clk, i_rst_n, o_out_valid && !o_out_data.served, (o_out_data.wait_ticks == '0) && (o_out_data.served_priority == CLS_LOW), "unserved result carries a wait or class")
    // Each served result advances the served count by exactly one.
    `SPL_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, w_load && r_serve, r_served_total == $past(r_served_total) + 1'b1, "served count did not advance by one")
    // A result is only loaded once the finish step is reached.
    `SPL_ASSERT_IMPL(a_load_in_finish, i_clk, i_rst_n, w_load, r_state == ST_FINISH, "result loaded outside the finish step")

endmodule
